/* sv/hlt_pkg.sv */
// Shared types, constants and control structs for the handle list table.
package hlt_pkg;

  localparam int CAPACITY     = 64;
  localparam int HANDLE_WIDTH = 32;
  localparam int KIND_W       = 3;
  localparam int IN_HANDLE_W  = 32;
  localparam int POS_W        = 7;
  localparam int STAT_W       = 2;
  localparam int LEN_W        = 7;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CMP_W        = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND, K_INSERT, K_GET, K_DROP_AT, K_DROP_VAL, K_CONTAINS, K_CLEAR, K_NOP
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK, ST_NULL, ST_RANGE, ST_FULL
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN, S_SHIFT, S_INS, S_INS_TAIL, S_INS_PUT,
    S_GET_RD, S_GET_WAIT, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_POS, PTR_CNTM1, PTR_INC, PTR_DEC
  } ptr_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_APPEND, WR_UP, WR_DOWN, WR_PUT
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    logic    rd_en;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    set_status;
    status_t status;
    logic    take_hout;
    logic    set_found;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  h_zero;
    logic  pos_gt_cnt;
    logic  pos_ge_cnt;
    logic  full;
    logic  ptr_lt_cnt;
    logic  ptr_eq_pos;
    logic  rd_vld;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

/* sv/hlt_ctrl.sv */
// Sequencer that walks each request through the list store.
module hlt_ctrl
  import hlt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic idle
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    idle      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        unique case (sts.kind)
          K_APPEND: begin
            priority if (sts.h_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NULL;
            end else if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_op  = WR_APPEND;
              cmd.cnt_op = CNT_INC;
            end
          end
          K_INSERT: begin
            priority if (sts.h_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NULL;
            end else if (sts.pos_gt_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else if (!sts.pos_ge_cnt) begin
              cmd.ptr_op = PTR_CNTM1;
              state_nxt  = S_INS;
            end else begin
              cmd.wr_op  = WR_APPEND;
              cmd.cnt_op = CNT_INC;
            end
          end
          K_GET: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.ptr_op = PTR_POS;
              state_nxt  = S_GET_RD;
            end
          end
          K_DROP_AT: begin
            if (sts.pos_ge_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.ptr_op = PTR_POS;
              state_nxt  = S_SCAN;
            end
          end
          K_DROP_VAL, K_CONTAINS: begin
            if (!sts.h_zero) begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = S_SCAN;
            end
          end
          K_CLEAR: cmd.cnt_op = CNT_CLR;
          K_NOP:   ;
          default: ;
        endcase
      end
      S_SCAN: begin
        // keep one read in flight ahead of the compare
        if (sts.ptr_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.ptr_op = PTR_INC;
        end
        if (sts.rd_vld && sts.match) begin
          cmd.set_found = (sts.kind != K_DROP_AT);
          if (sts.kind == K_CONTAINS) begin
            state_nxt = S_DONE;
          end else begin
            cmd.take_hout = 1'b1;
            state_nxt     = S_SHIFT;
          end
        end else if (!sts.rd_vld && !sts.ptr_lt_cnt) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts.ptr_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.ptr_op = PTR_INC;
        end
        if (sts.rd_vld) begin
          cmd.wr_op = WR_DOWN;
        end
        if (!sts.rd_vld && !sts.ptr_lt_cnt) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end
      end
      S_INS: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_vld) begin
          cmd.wr_op = WR_UP;
        end
        if (sts.ptr_eq_pos) begin
          state_nxt = S_INS_TAIL;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_INS_TAIL: begin
        cmd.wr_op = WR_UP;
        state_nxt = S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd.wr_op  = WR_PUT;
        cmd.cnt_op = CNT_INC;
        state_nxt  = S_DONE;
      end
      S_GET_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_GET_WAIT;
      end
      S_GET_WAIT: begin
        cmd.take_hout = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* sv/hlt_dp.sv */
// Datapath: entry store, count, walk pointer, result and output registers.
module hlt_dp
  import hlt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [IN_HANDLE_W-1:0] in_handle,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [IN_HANDLE_W-1:0] out_handle_out,
  output logic                   out_found,
  output logic [LEN_W-1:0]       out_length
);

  logic [HANDLE_WIDTH-1:0] entries_r [CAPACITY];

  kind_t                   kind_r;
  logic [HANDLE_WIDTH-1:0] h_r;
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        ptr_r;
  logic [CNT_W-1:0]        ptr_nxt;
  logic                    vld_r;
  logic [IDX_W-1:0]        addr_r;
  logic [HANDLE_WIDTH-1:0] rd_data_r;
  status_t                 status_r;
  logic [HANDLE_WIDTH-1:0] hout_r;
  logic                    found_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [HANDLE_WIDTH-1:0] out_hout_r;
  logic                    out_found_r;
  logic [CNT_W-1:0]        out_len_r;

  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic [CMP_W-1:0]        ptr_ext;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [HANDLE_WIDTH-1:0] wr_data;

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);
  assign ptr_ext = CMP_W'(ptr_r);

  always_comb begin
    sts.kind       = kind_r;
    sts.h_zero     = (h_r == '0);
    sts.pos_gt_cnt = (pos_ext > cnt_ext);
    sts.pos_ge_cnt = (pos_ext >= cnt_ext);
    sts.full       = (count_r >= CNT_W'(CAPACITY));
    sts.ptr_lt_cnt = (ptr_r < count_r);
    sts.ptr_eq_pos = (ptr_ext == pos_ext);
    sts.rd_vld     = vld_r;
    sts.match      = (kind_r == K_DROP_AT) || (rd_data_r == h_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD:  ptr_nxt = ptr_r;
      PTR_ZERO:  ptr_nxt = '0;
      PTR_POS:   ptr_nxt = CNT_W'(pos_r);
      PTR_CNTM1: ptr_nxt = count_r - CNT_W'(1);
      PTR_INC:   ptr_nxt = ptr_r + CNT_W'(1);
      PTR_DEC:   ptr_nxt = ptr_r - CNT_W'(1);
      default:   ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: count_nxt = count_r;
      CNT_INC:  count_nxt = count_r + CNT_W'(1);
      CNT_DEC:  count_nxt = count_r - CNT_W'(1);
      CNT_CLR:  count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = addr_r;
    wr_data = rd_data_r;
    unique case (cmd.wr_op)
      WR_NONE:   wr_en = 1'b0;
      WR_APPEND: begin
        wr_addr = count_r[IDX_W-1:0];
        wr_data = h_r;
      end
      WR_UP:     wr_addr = addr_r + IDX_W'(1);
      WR_DOWN:   wr_addr = addr_r - IDX_W'(1);
      WR_PUT: begin
        wr_addr = IDX_W'(pos_r);
        wr_data = h_r;
      end
      default:   wr_en = 1'b0;
    endcase
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= entries_r[ptr_r[IDX_W-1:0]];
      addr_r    <= ptr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      vld_r   <= cmd.rd_en;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      kind_r   <= kind_t'(in_kind);
      h_r      <= HANDLE_WIDTH'(in_handle);
      pos_r    <= in_position;
      status_r <= ST_OK;
      hout_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.take_hout) begin
        hout_r <= rd_data_r;
      end
      if (cmd.set_found) begin
        found_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_hout_r   <= hout_r;
      out_found_r  <= found_r;
      out_len_r    <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle_out = IN_HANDLE_W'(out_hout_r);
  assign out_found      = out_found_r;
  assign out_length     = LEN_W'(out_len_r);

endmodule

/* sv/handle_list_table.sv */
// Top level of the handle list table: ordered list of nonzero handles.
//
// One request at a time walks through a single store of 64 handles with one
// write port and one registered read port. Append, clear and the unused kind
// walk no entries, and get reads one. Insert moves every entry from the
// position to the end up by one, the drops move every entry after the
// removed one down by one, and a search reads from the head until it hits a
// match or the end, all one entry per clock through the store's read port.
// A finished result sits in the output register until taken, and the next
// request is accepted meanwhile. The store is never cleared; only entries
// below the current length are ever read.
module handle_list_table
  import hlt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [IN_HANDLE_W-1:0] in_handle,
  input  logic [POS_W-1:0]       in_position,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [IN_HANDLE_W-1:0] out_handle_out,
  output logic                   out_found,
  output logic [LEN_W-1:0]       out_length
);

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic start;

  // take a request only while the sequencer is idle
  assign in_stall = !idle;
  assign start    = in_valid && idle;

  hlt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .idle  (idle)
  );

  hlt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_handle      (in_handle),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_handle_out (out_handle_out),
    .out_found      (out_found),
    .out_length     (out_length)
  );

  // an accepted request keeps the input side stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // a rejected request carries no handle and no match
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_handle_out == '0) && !out_found)
    else $error("rejected request returned data");

  // reported length never exceeds the store size
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CNT_W'(out_length) <= CNT_W'(CAPACITY)))
    else $error("length beyond capacity");

  // the store cannot grow past capacity: a full result leaves length at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (CNT_W'(out_length) == CNT_W'(CAPACITY)))
    else $error("full reported below capacity");

endmodule
